[rtl/pmax2d_pkg.sv]
`default_nettype none

package pmax2d_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned NUM_COLS_W = 7;
  localparam int unsigned NUM_ROWS_W = 16;

  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 7'd64;
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS = 1'b0,
    CFG_NUM_ROWS = 1'b1
  } cfg_reg_e;

  // Where an item sits in the frame, worked out when it is accepted.
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic last_col;
    logic last_frame;
  } pos_t;

endpackage

`default_nettype wire

[rtl/pmax2d_pos.sv]
`default_nettype none

module pmax2d_pos import pmax2d_pkg::*; #(
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data_i,
  input  wire logic                                step_i,
  output logic      [$clog2(MAX_COLS)-1:0]         col_o,
  output pos_t                                     pos_o
);

  localparam int unsigned AW    = $clog2(MAX_COLS);
  localparam int unsigned CMP_W = (AW + 1 > NUM_COLS_W) ? AW + 1 : NUM_COLS_W;

  logic [NUM_COLS_W-1:0] num_cols_q;
  logic [NUM_ROWS_W-1:0] num_rows_q;
  logic [AW-1:0]         col_q, col_d;
  logic [NUM_ROWS_W-1:0] row_q, row_d;

  logic [CMP_W-1:0]      nc_w;
  logic [CMP_W-1:0]      cols_eff;
  logic [NUM_ROWS_W-1:0] rows_eff;
  logic                  last_col;
  logic                  last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_RST;
      num_rows_q <= NUM_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_COLS: num_cols_q <= cfg_data_i[NUM_COLS_W-1:0];
        CFG_NUM_ROWS: num_rows_q <= cfg_data_i[NUM_ROWS_W-1:0];
      endcase
    end
  end

  // A column count of zero acts as one and anything above the line store depth
  // is clipped to it; a row count of zero acts as one.
  always_comb begin
    nc_w = CMP_W'(num_cols_q);
    if (nc_w == '0) begin
      cols_eff = CMP_W'(1);
    end else if (nc_w > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = nc_w;
    end
    rows_eff = (num_rows_q == '0) ? NUM_ROWS_W'(1) : num_rows_q;

    last_col = (CMP_W'(col_q) + CMP_W'(1)) >= cols_eff;
    last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff};

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + NUM_ROWS_W'(1);
    end else begin
      col_d = col_q + AW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o            = col_q;
  assign pos_o.first_col  = (col_q == '0);
  assign pos_o.first_row  = (row_q == '0);
  assign pos_o.last_col   = last_col;
  assign pos_o.last_frame = last_col & last_row;

endmodule

`default_nettype wire

[rtl/pmax2d_line.sv]
`default_nettype none

module pmax2d_line import pmax2d_pkg::*; #(
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(MAX_COLS)-1:0] wr_addr_i,
  input  wire logic [DATA_WIDTH-1:0]       wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(MAX_COLS)-1:0] rd_addr_i,
  output logic      [DATA_WIDTH-1:0]       rd_data_o
);

  logic [DATA_WIDTH-1:0] mem [MAX_COLS];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] byp_data_q;
  logic                  byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // With a single column the entry being read is written on the same edge, so
  // the new value is carried round the array.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

[rtl/prefix_max_2d_stream.sv]
`default_nettype none
// Two-dimensional prefix maximum over a raster stream of signed elements.
// Each result passes through an input register, then a result register;
// one line store read per item keeps it at one item per cycle.
// Throughput: one item per clock, sustained while the output side is ready.
// Reset clears the position counters, the handshake state and the configuration
// (64 columns, one row); the line store is not cleared and needs no sweep.

module prefix_max_2d_stream import pmax2d_pkg::*; #(
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data_i,
  // input stream
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,  // sample
  // output stream
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic      [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,  // running_max
  output logic                                     m_axis_tuser_o,  // row_end
  output logic                                     m_axis_tlast_o   // frame_end
);

  localparam int unsigned AW     = $clog2(MAX_COLS);
  localparam int unsigned TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  logic                  in_acc;
  logic                  s1_go;
  logic                  out_free;

  logic [AW-1:0]         col;
  pos_t                  pos;

  logic                  s1_vld_q;
  logic [DATA_WIDTH-1:0] s1_sample_q;
  logic [AW-1:0]         s1_col_q;
  pos_t                  s1_pos_q;

  logic [DATA_WIDTH-1:0] above;
  logic [DATA_WIDTH-1:0] left_q;
  logic [DATA_WIDTH-1:0] x_left;
  logic [DATA_WIDTH-1:0] x_d;

  logic                  out_vld_q;
  logic [DATA_WIDTH-1:0] out_max_q;
  logic                  out_row_end_q;
  logic                  out_frame_end_q;

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s1_go           = s1_vld_q && out_free;
  assign s_axis_tready_o = !s1_vld_q || s1_go;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  pmax2d_pos #(
    .MAX_COLS (MAX_COLS)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_acc),
    .col_o       (col),
    .pos_o       (pos)
  );

  pmax2d_line #(
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (x_d),
    .rd_en_i   (in_acc),
    .rd_addr_i (col),
    .rd_data_o (above)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= s_axis_tdata_i[DATA_WIDTH-1:0];
      s1_col_q    <= col;
      s1_pos_q    <= pos;
    end
  end

  // Missing neighbours on the first row or column are simply left out.
  always_comb begin
    x_left = s1_sample_q;
    if (!s1_pos_q.first_col && ($signed(left_q) > $signed(x_left))) begin
      x_left = left_q;
    end
    x_d = x_left;
    if (!s1_pos_q.first_row && ($signed(above) > $signed(x_left))) begin
      x_d = above;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      left_q          <= x_d;
      out_max_q       <= x_d;
      out_row_end_q   <= s1_pos_q.last_col;
      out_frame_end_q <= s1_pos_q.last_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDATA_W'(out_max_q);
  assign m_axis_tuser_o  = out_row_end_q;
  assign m_axis_tlast_o  = out_frame_end_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
module testbench;
  import pmax2d_pkg::*;

  localparam int unsigned DW          = 32;
  localparam int unsigned LINE_DEPTH  = 64;
  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [DW-1:0] mx;
    logic          row_end;
    logic          frame_end;
  } max_result_t;

  typedef enum logic {
    OP_ITEM,
    OP_CFG
  } dir_op_e;

  // One row of the directed part: an item or a register write, and for items an
  // optional expected result that can be read straight off the behaviour.
  typedef struct packed {
    dir_op_e       op;
    cfg_reg_e      idx;
    logic [DW-1:0] value;
    logic          pin;
    logic [DW-1:0] pmax;
    logic          prow;
    logic          pframe;
  } dir_row_t;

  localparam int unsigned N_DIR = 27;

  dir_row_t dir_tab [N_DIR] = '{
    '{OP_ITEM, CFG_NUM_COLS, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    // Zero columns mid-row: the counter already lies beyond the last column.
    '{OP_CFG,  CFG_NUM_COLS, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1},
    '{OP_ITEM, CFG_NUM_COLS, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFB, 1'b1, 1'b1},
    '{OP_CFG,  CFG_NUM_ROWS, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b1},
    '{OP_ITEM, CFG_NUM_COLS, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b1},
    // All data bits set: 127 columns, which acts as the full line length.
    '{OP_CFG,  CFG_NUM_COLS, 32'h0000_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_CFG,  CFG_NUM_ROWS, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h5555_5555, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_CFG,  CFG_NUM_COLS, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h7FFF_FFFE, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_CFG,  CFG_NUM_COLS, 32'h0000_0003, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_CFG,  CFG_NUM_ROWS, 32'h0000_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0001, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    // One row while already in the second row: this row closes the frame.
    '{OP_CFG,  CFG_NUM_ROWS, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
    '{OP_ITEM, CFG_NUM_COLS, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, 1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DW-1:0]         s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DW-1:0]         m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // Predictor state.
  logic signed [DW-1:0]   line_store [LINE_DEPTH];
  bit                     written    [LINE_DEPTH];
  logic signed [DW-1:0]   left_max;
  int                     col_idx;
  int                     row_idx;
  logic [NUM_COLS_W-1:0]  cols_reg;
  logic [NUM_ROWS_W-1:0]  rows_reg;

  max_result_t pending_max_q [$];
  bit          pin_on;
  max_result_t pin_val;
  bit          calm;
  bit          hold_req;
  int          ramp_level;

  int n_err;
  int n_sent;
  int n_out;
  int n_cfg;
  int n_frames;
  int n_in_stalls;
  int n_holds;

  prefix_max_2d_stream #(
    .MAX_COLS  (LINE_DEPTH),
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // sample
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // running_max
    .m_axis_tuser_o (m_tuser),   // row_end
    .m_axis_tlast_o (m_tlast)    // frame_end
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int eff_cols_of(input logic [NUM_COLS_W-1:0] cols);
    if (cols == 0) return 1;
    if (cols > LINE_DEPTH) return LINE_DEPTH;
    return cols;
  endfunction

  // A wider row is only safe if every line store entry it will read has been filled.
  function automatic bit store_ready(input int eff_cols);
    if (row_idx == 0) return 1'b1;
    for (int j = 0; j < eff_cols; j++) begin
      if (!written[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_prefix_max(input logic [DW-1:0] sample, output max_result_t res);
    int                   eff_cols;
    int                   eff_rows;
    int                   slot;
    logic signed [DW-1:0] v;
    bit                   last_col;
    bit                   last_row;
    eff_cols = eff_cols_of(cols_reg);
    eff_rows = (rows_reg == 0) ? 1 : int'(rows_reg);
    slot     = (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
    v        = sample;
    if (col_idx > 0 && left_max > v) v = left_max;
    if (row_idx > 0 && line_store[slot] > v) v = line_store[slot];
    line_store[slot] = v;
    written[slot]    = 1'b1;
    left_max         = v;
    last_col = (col_idx + 1 >= eff_cols);
    last_row = (row_idx + 1 >= eff_rows);
    res.mx        = v;
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    if (last_col) begin
      col_idx  = 0;
      left_max = '0;
      row_idx  = last_row ? 0 : ((row_idx + 1) & 16'hFFFF);
    end else begin
      col_idx = col_idx + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    max_result_t e;
    max_result_t got;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_NUM_COLS: cols_reg = cfg_data[NUM_COLS_W-1:0];
        CFG_NUM_ROWS: rows_reg = cfg_data[NUM_ROWS_W-1:0];
        default: ;
      endcase
    end
    if (s_tvalid && s_tready) begin
      predict_prefix_max(s_tdata, e);
      if (pin_on) e = pin_val;
      pending_max_q.push_back(e);
    end
    if (s_tvalid && !s_tready) n_in_stalls++;
    if (m_tvalid && m_tready) begin
      got = '{mx: m_tdata, row_end: m_tuser, frame_end: m_tlast};
      n_out++;
      if (got.frame_end === 1'b1) n_frames++;
      if (pending_max_q.size() == 0) begin
        $display("%0t: result %h/%b/%b arrived with nothing expected", $time,
                 got.mx, got.row_end, got.frame_end);
        n_err++;
      end else begin
        e = pending_max_q.pop_front();
        if (got.mx !== e.mx) begin
          $display("%0t: running_max expected %h actual %h", $time, e.mx, got.mx);
          n_err++;
        end
        if (got.row_end !== e.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time, e.row_end, got.row_end);
          n_err++;
        end
        if (got.frame_end !== e.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, got.frame_end);
          n_err++;
        end
      end
    end
  end

  // Output side: a random stall before each item, and long hold-offs on request.
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [DW-1:0] value, input bit pin,
                             input max_result_t pinned);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    pin_on  = pin;
    pin_val = pinned;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [DW-1:0] pick_sample(input int style);
    case (style)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: return $urandom_range(0, 16) - 8;
      default: begin
        // Slowly rising values keep the running maximum moving.
        ramp_level = ramp_level + $urandom_range(0, 3);
        return ramp_level - $urandom_range(0, 24);
      end
    endcase
  endfunction

  initial begin
    int                    phase;
    int                    len;
    int                    style;
    logic [CFG_DATA_W-1:0] cols_pick;
    logic [CFG_DATA_W-1:0] rows_pick;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_COLS;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    pin_on    = 1'b0;
    pin_val   = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    for (int j = 0; j < LINE_DEPTH; j++) begin
      line_store[j] = '0;
      written[j]    = 1'b0;
    end
    left_max = '0;
    col_idx  = 0;
    row_idx  = 0;
    cols_reg = NUM_COLS_RST;
    rows_reg = NUM_ROWS_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].op == OP_CFG) begin
        cfg_write(dir_tab[i].idx, dir_tab[i].value[CFG_DATA_W-1:0]);
      end else begin
        send_sample(dir_tab[i].value, dir_tab[i].pin,
                    '{mx: dir_tab[i].pmax, row_end: dir_tab[i].prow,
                      frame_end: dir_tab[i].pframe});
      end
    end

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        cols_pick = $urandom;
        case ($urandom_range(0, 9))
          0:       cols_pick[NUM_COLS_W-1:0] = 0;
          1:       cols_pick[NUM_COLS_W-1:0] = 64;
          2:       cols_pick[NUM_COLS_W-1:0] = $urandom_range(65, 127);
          3:       cols_pick[NUM_COLS_W-1:0] = $urandom_range(9, 63);
          default: cols_pick[NUM_COLS_W-1:0] = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
          0:       rows_pick = 0;
          1:       rows_pick = 16'hFFFF;
          2:       rows_pick = $urandom;
          default: rows_pick = $urandom_range(1, 6);
        endcase
        drain_results();
        if (!store_ready(eff_cols_of(cols_pick[NUM_COLS_W-1:0]))) begin
          // Close the frame at the end of this row before widening it.
          cfg_write(CFG_NUM_ROWS, 16'd1);
          while (row_idx != 0 || col_idx != 0) begin
            send_sample(pick_sample(0), 1'b0, '0);
            drain_results();
          end
        end
        if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CFG_NUM_COLS, cols_pick);
        if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CFG_NUM_ROWS, rows_pick);
      end
      style      = $urandom_range(0, 3);
      ramp_level = $urandom;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 60);
      if (phase == 0 || $urandom_range(0, 7) == 0) begin
        // The output side holds off while items keep coming back to back.
        calm     = 1'b1;
        hold_req = 1'b1;
        if (len < 60) len = 60;
      end else begin
        calm = ($urandom_range(0, 5) == 0);
      end
      repeat (len) begin
        send_sample(($urandom_range(0, 7) == 0) ? pick_sample(0) : pick_sample(style),
                    1'b0, '0);
      end
      calm = 1'b0;
      phase++;
    end

    drain_results();
    repeat (10) @(negedge clk);
    $display("summary: %0d items in, %0d results checked, %0d frames closed", n_sent,
             n_out, n_frames);
    $display("summary: %0d register writes, %0d input stall cycles, %0d output hold-offs",
             n_cfg, n_in_stalls, n_holds);
    if (n_err == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
